FILE: rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types, constants, microcode table and helpers of the state
// variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

	// default parameter values
	localparam int DEF_CHANNELS    = 2;
	localparam int DEF_SAMPLE_BITS = 24;

	// fixed widths
	localparam int COEFF_W = 18;     // unsigned Q2.16
	localparam int TYPE_W  = 2;
	localparam int STATE_W = 32;     // saturating filter state
	localparam int ACC_W   = 36;     // unsaturated intermediate sums
	localparam int MUL_W   = STATE_W + COEFF_W + 1;
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = COEFF_W;
	localparam int IDX_W   = 2;

	// configuration register indexes
	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_FREQ = 2'd0;
	localparam reg_idx_t REG_DAMP = 2'd1;
	localparam reg_idx_t REG_TYPE = 2'd2;

	localparam logic [COEFF_W-1:0] FREQ_RST = 18'd8573;
	localparam logic [COEFF_W-1:0] DAMP_RST = 18'd92682;

	// response select
	typedef enum logic [TYPE_W-1:0] {
		RESP_LOW   = 2'd0,
		RESP_BAND  = 2'd1,
		RESP_NOTCH = 2'd2,
		RESP_HIGH  = 2'd3
	} resp_t;

	localparam resp_t TYPE_RST = RESP_LOW;

	// microcode fields
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		SRC_X, SRC_D1, SRC_D2, SRC_LOW, SRC_HIGH, SRC_TMP, SRC_PROD
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_LOW, DST_TMP, DST_HIGH, DST_NOTCH, DST_BAND
	} dst_t;

	typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;
	typedef enum logic {MA_D1, MA_HIGH} mul_a_t;
	typedef enum logic {MB_FREQ, MB_DAMP} mul_b_t;
	typedef enum logic {COND_ALWAYS, COND_OUT_BUSY} cond_t;

	typedef struct packed {
		logic    mul_en;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		src_t    alu_a;
		src_t    alu_b;
		alu_op_t alu_op;
		dst_t    dst;
		logic    state_wr;
		logic    emit;
		logic    jmp_en;
		cond_t   jmp_cond;
		step_t   jmp_tgt;
		logic    last;
	} ctrl_t;

	typedef struct packed {
		logic  busy;
		step_t step;
	} seq_stat_t;

	localparam ctrl_t CTRL_NOP = '0;

	// program: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = CTRL_NOP;
		case (s)
			3'd0: begin
				// prod = d1 * f
				w.mul_en = 1'b1;
				w.mul_a  = MA_D1;
				w.mul_b  = MB_FREQ;
			end
			3'd1: begin
				// low = d2 + d1*f ; prod = d1 * damping
				w.alu_a  = SRC_D2;
				w.alu_b  = SRC_PROD;
				w.alu_op = ALU_ADD;
				w.dst    = DST_LOW;
				w.mul_en = 1'b1;
				w.mul_a  = MA_D1;
				w.mul_b  = MB_DAMP;
			end
			3'd2: begin
				// tmp = x - low
				w.alu_a  = SRC_X;
				w.alu_b  = SRC_LOW;
				w.alu_op = ALU_SUB;
				w.dst    = DST_TMP;
			end
			3'd3: begin
				// high = tmp - d1*damping
				w.alu_a  = SRC_TMP;
				w.alu_b  = SRC_PROD;
				w.alu_op = ALU_SUB;
				w.dst    = DST_HIGH;
			end
			3'd4: begin
				// notch = high + low ; prod = high * f
				w.alu_a  = SRC_HIGH;
				w.alu_b  = SRC_LOW;
				w.alu_op = ALU_ADD;
				w.dst    = DST_NOTCH;
				w.mul_en = 1'b1;
				w.mul_a  = MA_HIGH;
				w.mul_b  = MB_FREQ;
			end
			3'd5: begin
				// band = high*f + d1
				w.alu_a  = SRC_PROD;
				w.alu_b  = SRC_D1;
				w.alu_op = ALU_ADD;
				w.dst    = DST_BAND;
			end
			3'd6: begin
				// write back state, emit once the output slot is free
				w.state_wr = 1'b1;
				w.emit     = 1'b1;
				w.jmp_en   = 1'b1;
				w.jmp_cond = COND_OUT_BUSY;
				w.jmp_tgt  = 3'd6;
				w.last     = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	// clamp a wide sum to signed 32 bits
	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'({1'b0, {(STATE_W-1){1'b1}}}));
		lo = ACC_W'(signed'({1'b1, {(STATE_W-1){1'b0}}}));
		if (v > hi) begin
			return hi[STATE_W-1:0];
		end else if (v < lo) begin
			return lo[STATE_W-1:0];
		end
		return v[STATE_W-1:0];
	endfunction

endpackage

FILE: rtl/svf_if.sv
// ----------------------------------------------------------------------------
// svf_if
// Valid/ready channels of the state variable filter: sample in, result out.
// ----------------------------------------------------------------------------
interface svf_in_if import svf_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          channel_in;

	modport source (output valid, output sample_in, output channel_in, input ready);
	modport sink   (input valid, input sample_in, input channel_in, output ready);
endinterface

interface svf_out_if import svf_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          channel_out;

	modport source (output valid, output filtered, output channel_out, input ready);
	modport sink   (input valid, input filtered, input channel_out, output ready);
endinterface

FILE: rtl/svf_seq.sv
// ----------------------------------------------------------------------------
// svf_seq
// Microcode sequencer: step counter, program table and conditional jump.
// ----------------------------------------------------------------------------
module svf_seq import svf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      out_busy,
	output ctrl_t     ctrl,
	output seq_stat_t stat
);

	logic  busy_q;
	step_t step_q;
	ctrl_t word;
	logic  taken;

	assign word  = ucode(step_q);
	assign taken = busy_q && word.jmp_en &&
		((word.jmp_cond == COND_ALWAYS) || ((word.jmp_cond == COND_OUT_BUSY) && out_busy));

	always_comb begin
		ctrl = busy_q ? word : CTRL_NOP;
		// a taken jump holds the step: no beat leaves, the program does not end
		if (taken) begin
			ctrl.emit = 1'b0;
			ctrl.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (taken) begin
				step_q <= word.jmp_tgt;
			end else if (word.last) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.step = step_q;

endmodule

FILE: rtl/state_variable_filter_core.sv
// ----------------------------------------------------------------------------
// state_variable_filter_core
// Multi-channel Chamberlin state variable filter, fixed point, microcoded.
// ----------------------------------------------------------------------------
// usage
// - sample_ch takes one beat per sample: a signed sample and its channel tag
// - result_ch gives one beat per sample: the selected response, clamped to
//   the sample width, with the channel tag echoed
// - cfg_wr_en/cfg_index/cfg_data write freq_coeff (0), damping_coeff (1) and
//   response_type (2); other indexes are dropped; write only while idle
// - one sample runs a seven-step program on one shared 32x19 multiplier and
//   one 36-bit adder, so sample_ch is not ready again until the program ends
// - the result sits in an output register: the next sample is taken while
//   it waits, and the program stalls at its last step while the receiver
//   holds off and the slot is still full
// - reset clears the channel state to zero, loads the coefficient defaults
//   and empties the output register; the block is ready right after reset
// ----------------------------------------------------------------------------
module state_variable_filter_core import svf_pkg::*; #(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  reg_idx_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	svf_in_if.sink            sample_ch,
	svf_out_if.source         result_ch
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [STATE_W:0] OUT_MAX =
		(33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
	localparam logic signed [STATE_W:0] OUT_MIN = -OUT_MAX - 33'sd1;

	// configuration registers
	logic [COEFF_W-1:0] freq_q;
	logic [COEFF_W-1:0] damp_q;
	resp_t              resp_q;

	// per-channel filter state
	logic signed [STATE_W-1:0] band_dly_q [CHANNELS];
	logic signed [STATE_W-1:0] low_dly_q  [CHANNELS];

	// working registers of one sample
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          ch_q;
	logic [CH_W-1:0]               idx_q;
	logic signed [STATE_W-1:0]     d1_q;
	logic signed [STATE_W-1:0]     d2_q;
	logic signed [STATE_W-1:0]     low_q;
	logic signed [STATE_W-1:0]     high_q;
	logic signed [STATE_W-1:0]     notch_q;
	logic signed [STATE_W-1:0]     band_q;
	logic signed [ACC_W-1:0]       tmp_q;
	logic signed [ACC_W-1:0]       prod_q;

	// output register
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_ch_q;

	ctrl_t     ctrl;
	seq_stat_t stat;
	logic      accept;
	logic      out_busy;
	logic      out_load;
	logic [CH_W-1:0] in_idx;

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign sample_ch.ready = !stat.busy;
	assign accept          = sample_ch.valid && !stat.busy;
	assign out_busy        = out_vld_q && !result_ch.ready;
	assign out_load        = ctrl.emit;

	// channel tag folded onto the implemented channels
	assign in_idx = (CHANNELS == 1) ? '0 : CH_W'(sample_ch.channel_in);

	svf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_busy (out_busy),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RST;
			damp_q <= DAMP_RST;
			resp_q <= TYPE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FREQ: freq_q <= cfg_data[COEFF_W-1:0];
				REG_DAMP: damp_q <= cfg_data[COEFF_W-1:0];
				REG_TYPE: resp_q <= resp_t'(cfg_data[TYPE_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// multiplier: v * c, round half up, drop 16 fraction bits
	// ------------------------------------------------------------------
	logic signed [STATE_W-1:0] mul_a;
	logic signed [COEFF_W:0]   mul_b;
	logic signed [MUL_W-1:0]   mul_full;
	logic signed [MUL_W-1:0]   mul_rnd;

	assign mul_a    = (ctrl.mul_a == MA_HIGH) ? high_q : d1_q;
	assign mul_b    = signed'({1'b0, (ctrl.mul_b == MB_DAMP) ? damp_q : freq_q});
	assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
	assign mul_rnd  = mul_full + MUL_W'(32768);

	// ------------------------------------------------------------------
	// adder
	// ------------------------------------------------------------------
	function automatic logic signed [ACC_W-1:0] pick(
		input src_t                      s,
		input logic signed [SAMPLE_BITS-1:0] x,
		input logic signed [STATE_W-1:0] d1,
		input logic signed [STATE_W-1:0] d2,
		input logic signed [STATE_W-1:0] lo,
		input logic signed [STATE_W-1:0] hi,
		input logic signed [ACC_W-1:0]   tmp,
		input logic signed [ACC_W-1:0]   prod
	);
		case (s)
			SRC_X:    return ACC_W'(x);
			SRC_D1:   return ACC_W'(d1);
			SRC_D2:   return ACC_W'(d2);
			SRC_LOW:  return ACC_W'(lo);
			SRC_HIGH: return ACC_W'(hi);
			SRC_TMP:  return tmp;
			SRC_PROD: return prod;
			default:  return '0;
		endcase
	endfunction

	logic signed [ACC_W-1:0]   alu_a;
	logic signed [ACC_W-1:0]   alu_b;
	logic signed [ACC_W-1:0]   alu_res;
	logic signed [STATE_W-1:0] alu_sat;

	assign alu_a   = pick(ctrl.alu_a, x_q, d1_q, d2_q, low_q, high_q, tmp_q, prod_q);
	assign alu_b   = pick(ctrl.alu_b, x_q, d1_q, d2_q, low_q, high_q, tmp_q, prod_q);
	assign alu_res = (ctrl.alu_op == ALU_SUB) ? (alu_a - alu_b) : (alu_a + alu_b);
	assign alu_sat = sat32(alu_res);

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= sample_ch.sample_in;
			ch_q  <= sample_ch.channel_in;
			idx_q <= in_idx;
			d1_q  <= band_dly_q[in_idx];
			d2_q  <= low_dly_q[in_idx];
		end
		if (ctrl.mul_en) begin
			prod_q <= ACC_W'(signed'(mul_rnd[MUL_W-1:FRAC_W]));
		end
		case (ctrl.dst)
			DST_LOW:   low_q   <= alu_sat;
			DST_TMP:   tmp_q   <= alu_res;
			DST_HIGH:  high_q  <= alu_sat;
			DST_NOTCH: notch_q <= alu_sat;
			DST_BAND:  band_q  <= alu_sat;
			default: begin
			end
		endcase
	end

	// channel state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				band_dly_q[i] <= '0;
				low_dly_q[i]  <= '0;
			end
		end else if (ctrl.state_wr) begin
			band_dly_q[idx_q] <= band_q;
			low_dly_q[idx_q]  <= low_q;
		end
	end

	// ------------------------------------------------------------------
	// response select and clamp to sample width
	// ------------------------------------------------------------------
	logic signed [STATE_W-1:0] sel;
	logic signed [STATE_W:0]   sel_w;
	logic signed [STATE_W:0]   sel_clip;

	always_comb begin
		case (resp_q)
			RESP_BAND:  sel = band_q;
			RESP_NOTCH: sel = notch_q;
			RESP_HIGH:  sel = high_q;
			default:    sel = low_q;
		endcase
		sel_w = (STATE_W + 1)'(sel);
		if (sel_w > OUT_MAX) begin
			sel_clip = OUT_MAX;
		end else if (sel_w < OUT_MIN) begin
			sel_clip = OUT_MIN;
		end else begin
			sel_clip = sel_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= sel_clip[SAMPLE_BITS-1:0];
			out_ch_q   <= ch_q;
		end
	end

	assign result_ch.valid       = out_vld_q;
	assign result_ch.filtered    = out_data_q;
	assign result_ch.channel_out = out_ch_q;

`ifndef ASSERT_OFF
	// an input beat starts the program at its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.busy && (stat.step == '0))
		else $error("program did not start on input beat");

	// the output register is only loaded when its beat has left or leaves now
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || result_ch.ready))
		else $error("result overwritten before it was taken");

	// emitting a result ends the program and frees the input
	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !stat.busy)
		else $error("sequencer still busy after emit");

	// state is only written back while a sample is in flight
	a_state_wr: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.state_wr |-> stat.busy && !accept)
		else $error("state write outside a program");
`endif

endmodule
